// File: rtl/core/min_cover_window_core_macros.svh
// assertion macros shared by the min cover window rtl
`ifndef MIN_COVER_WINDOW_CORE_MACROS_SVH
`define MIN_COVER_WINDOW_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// next-cycle implication, checked out of reset
`define MCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

// File: rtl/core/mcw_pkg.sv
// types and constants of the min cover window block
`timescale 1ns / 1ps
`default_nettype none

package mcw_pkg;

  localparam int unsigned POS_IN_W   = 32;
  localparam int unsigned WORD_IN_W  = 10;
  localparam int unsigned NWORDS_W   = 11;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 32;
  localparam int unsigned M_TUSER_W  = 2;
  localparam int unsigned EPOCH_W    = 8;

  localparam logic [LEN_W-1:0]    ALL_ONES32  = '1;
  localparam logic [EPOCH_W-1:0]  EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0]  EPOCH_LAST  = '1;
  localparam logic [EPOCH_W-1:0]  EPOCH_CLEAR = '0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_HEAD_RD,
    ST_HEAD_LP,
    ST_HEAD_CMP,
    ST_SPAN,
    ST_DONE
  } mcw_state_e;

  typedef struct packed {
    logic accept;
    logic push;
    logic head_rd;
    logic head_lp;
    logic pop;
    logic span;
    logic load_out;
    logic clear_set;
    logic clear_wr;
  } mcw_cmd_t;

  typedef struct packed {
    logic in_range;
    logic head_match;
    logic fill_one;
    logic out_busy;
    logic clear_last;
    logic epoch_wrap;
    logic last;
  } mcw_status_t;

endpackage

`default_nettype wire

// File: rtl/core/mcw_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module mcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/mcw_datapath.sv
// datapath: position store, window fifo, span compare and result register
`timescale 1ns / 1ps
`default_nettype none
`include "min_cover_window_core_macros.svh"

module mcw_datapath
  import mcw_pkg::*;
#(
  parameter int unsigned MAX_WORDS    = 1024,
  parameter int unsigned WINDOW_DEPTH = 4096,
  parameter int unsigned POS_BITS     = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mcw_cmd_t              cmd_i,
  output mcw_status_t                st_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [NWORDS_W-1:0]   cfg_data_i,
  input  wire logic [POS_IN_W-1:0]   position_i,
  input  wire logic [WORD_IN_W-1:0]  word_id_i,
  input  wire logic                  last_in_set_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [LEN_W-1:0]           min_length_o,
  output logic                       covered_o,
  output logic                       overflow_o
);

  localparam int unsigned WID_W  = $clog2(MAX_WORDS);
  localparam int unsigned NCNT_W = $clog2(MAX_WORDS + 1);
  localparam int unsigned CMP_W  = (NCNT_W > NWORDS_W) ? NCNT_W : NWORDS_W;
  localparam int unsigned PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SPAN_W = (POS_BITS + 1 > LEN_W + 1) ? POS_BITS + 1 : LEN_W + 1;
  localparam int unsigned LP_W   = EPOCH_W + POS_BITS;
  localparam int unsigned WIN_W  = WID_W + POS_BITS;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(WINDOW_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  logic [NWORDS_W-1:0] num_words_q, num_words_d;
  logic [EPOCH_W-1:0]  epoch_q, epoch_d;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [PTR_W-1:0]    tail_q, tail_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [NCNT_W-1:0]   distinct_q, distinct_d;
  logic [LEN_W-1:0]    best_q, best_d;
  logic                ovf_q, ovf_d;
  logic                cov_q, cov_d;
  logic [WID_W-1:0]    clr_cnt_q, clr_cnt_d;
  logic                out_valid_q, out_valid_d;

  logic [POS_BITS-1:0] pos_q;
  logic [WORD_IN_W-1:0] wid_q;
  logic                last_q;
  logic [POS_BITS-1:0] head_pos_q;
  logic [LEN_W-1:0]    out_len_q;
  logic                out_cov_q;
  logic                out_ovf_q;

  logic [CMP_W-1:0]    nw_ext;
  logic [CMP_W-1:0]    n_eff;
  logic [WID_W-1:0]    widx;
  logic                lp_we;
  logic [WID_W-1:0]    lp_waddr;
  logic [LP_W-1:0]     lp_wdata;
  logic                lp_re;
  logic [WID_W-1:0]    lp_raddr;
  logic [LP_W-1:0]     lp_rdata;
  logic [EPOCH_W-1:0]  lp_tag;
  logic [POS_BITS-1:0] lp_pos;
  logic [WIN_W-1:0]    win_rdata;
  logic [POS_BITS-1:0] win_pos;
  logic [WID_W-1:0]    win_id;
  logic                seen;
  logic                full;
  logic                cover_ok;
  logic [POS_BITS-1:0] diff;
  logic [SPAN_W-1:0]   span_ext;
  logic [LEN_W-1:0]    span_sat;

  // effective word count: zero acts as one, clamp at the store depth
  always_comb begin
    nw_ext = CMP_W'(num_words_q);
    if (nw_ext == '0) begin
      n_eff = CMP_W'(1);
    end else if (nw_ext > CMP_W'(MAX_WORDS)) begin
      n_eff = CMP_W'(MAX_WORDS);
    end else begin
      n_eff = nw_ext;
    end
  end

  assign widx     = WID_W'(wid_q);
  assign lp_tag   = lp_rdata[LP_W-1 -: EPOCH_W];
  assign lp_pos   = lp_rdata[POS_BITS-1:0];
  assign win_pos  = win_rdata[POS_BITS-1:0];
  assign win_id   = win_rdata[WIN_W-1:POS_BITS];

  assign lp_we    = cmd_i.push | cmd_i.clear_wr;
  assign lp_waddr = cmd_i.clear_wr ? clr_cnt_q : widx;
  assign lp_wdata = cmd_i.clear_wr ? {EPOCH_CLEAR, POS_BITS'(0)} : {epoch_q, pos_q};
  assign lp_re    = cmd_i.accept | cmd_i.head_lp;
  assign lp_raddr = cmd_i.head_lp ? win_id : WID_W'(word_id_i);

  mcw_ram #(
    .WIDTH (LP_W),
    .DEPTH (MAX_WORDS)
  ) u_last_pos (
    .clk_i   (clk_i),
    .we_i    (lp_we),
    .waddr_i (lp_waddr),
    .wdata_i (lp_wdata),
    .re_i    (lp_re),
    .raddr_i (lp_raddr),
    .rdata_o (lp_rdata)
  );

  mcw_ram #(
    .WIDTH (WIN_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (tail_q),
    .wdata_i ({widx, pos_q}),
    .re_i    (cmd_i.head_rd),
    .raddr_i (head_q),
    .rdata_o (win_rdata)
  );

  assign seen     = (lp_tag == epoch_q);
  assign full     = (fill_q == FILL_W'(WINDOW_DEPTH));
  assign cover_ok = (CMP_W'(distinct_q) >= n_eff) && (fill_q != '0);
  assign diff     = pos_q - head_pos_q;
  assign span_ext = SPAN_W'(diff) + SPAN_W'(1);
  assign span_sat = (span_ext > SPAN_W'(ALL_ONES32)) ? ALL_ONES32 : span_ext[LEN_W-1:0];

  always_comb begin
    num_words_d = num_words_q;
    epoch_d     = epoch_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    distinct_d  = distinct_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    cov_d       = cov_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q;

    if (cfg_we_i) begin
      num_words_d = cfg_data_i;
    end
    if (cmd_i.push) begin
      if (!seen) begin
        distinct_d = distinct_q + NCNT_W'(1);
      end
      tail_d = next_ptr(tail_q);
      if (full) begin
        head_d = next_ptr(head_q);
        ovf_d  = 1'b1;
      end else begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
    if (cmd_i.pop) begin
      head_d = next_ptr(head_q);
      fill_d = fill_q - FILL_W'(1);
    end
    if (cmd_i.span && cover_ok) begin
      if (span_sat < best_q) begin
        best_d = span_sat;
      end
      cov_d = 1'b1;
    end
    if (cmd_i.clear_set) begin
      epoch_d    = (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
      head_d     = '0;
      tail_d     = '0;
      fill_d     = '0;
      distinct_d = '0;
      best_d     = ALL_ONES32;
      ovf_d      = 1'b0;
      cov_d      = 1'b0;
    end
    if (cmd_i.clear_wr) begin
      clr_cnt_d = (clr_cnt_q == WID_W'(MAX_WORDS - 1)) ? '0 : clr_cnt_q + WID_W'(1);
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_words_q <= NWORDS_W'(1);
      epoch_q     <= EPOCH_FIRST;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      distinct_q  <= '0;
      best_q      <= ALL_ONES32;
      ovf_q       <= 1'b0;
      cov_q       <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      num_words_q <= num_words_d;
      epoch_q     <= epoch_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      distinct_q  <= distinct_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      cov_q       <= cov_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_q  <= POS_BITS'(position_i);
      wid_q  <= word_id_i;
      last_q <= last_in_set_i;
    end
    if (cmd_i.head_lp) begin
      head_pos_q <= win_pos;
    end
    if (cmd_i.load_out) begin
      out_len_q <= best_q;
      out_cov_q <= cov_q;
      out_ovf_q <= ovf_q;
    end
  end

  assign st_o.in_range   = (CMP_W'(wid_q) < n_eff);
  assign st_o.head_match = (lp_pos == head_pos_q);
  assign st_o.fill_one   = (fill_q == FILL_W'(1));
  assign st_o.out_busy   = out_valid_q && !out_ready_i;
  assign st_o.clear_last = (clr_cnt_q == WID_W'(MAX_WORDS - 1));
  assign st_o.epoch_wrap = (epoch_q == EPOCH_LAST);
  assign st_o.last       = last_q;

  assign out_valid_o  = out_valid_q;
  assign min_length_o = out_len_q;
  assign covered_o    = out_cov_q;
  assign overflow_o   = out_ovf_q;

  `MCW_ASSERT_NEXT(a_push_nonempty, cmd_i.push, fill_q != '0, "window empty after push")
  `MCW_ASSERT(a_best_needs_cover, !cov_q |-> best_q == ALL_ONES32, "best set without cover")

endmodule

`default_nettype wire

// File: rtl/core/mcw_ctrl.sv
// controller state machine sequencing store sweep, lookup, push, head drop and result
`timescale 1ns / 1ps
`default_nettype none
`include "min_cover_window_core_macros.svh"

module mcw_ctrl
  import mcw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire mcw_status_t st_i,
  output mcw_cmd_t         cmd_o
);

  mcw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (st_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (st_i.in_range) begin
          cmd_o.push = 1'b1;
          state_d    = ST_HEAD_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_HEAD_RD: begin
        cmd_o.head_rd = 1'b1;
        state_d       = ST_HEAD_LP;
      end
      ST_HEAD_LP: begin
        cmd_o.head_lp = 1'b1;
        state_d       = ST_HEAD_CMP;
      end
      ST_HEAD_CMP: begin
        if (st_i.head_match) begin
          state_d = ST_SPAN;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = st_i.fill_one ? ST_SPAN : ST_HEAD_RD;
        end
      end
      ST_SPAN: begin
        cmd_o.span = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!st_i.last) begin
          state_d = ST_IDLE;
        end else if (!st_i.out_busy) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.clear_set = 1'b1;
          state_d         = st_i.epoch_wrap ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `MCW_ASSERT(a_newest_kept, (state_q == ST_HEAD_CMP && !st_i.head_match) |-> !st_i.fill_one, "newest entry dropped")
  `MCW_ASSERT(a_no_overwrite, cmd_o.load_out |-> !st_i.out_busy, "result overwritten")

endmodule

`default_nettype wire

// File: rtl/core/min_cover_window_core.sv
// one item in flight: accept, lookup, push, then a head read, position lookup and compare
// per window head checked; a new item is taken only after the last one is done, the item
// rate set by the head loop through the window ram and the position ram, both with
// registered reads, and held while a set result waits on the sink
// after reset and every 255th set the position store is swept entry by entry
// with no item taken; rst_ni is asynchronous, active low
`timescale 1ns / 1ps
`default_nettype none

module min_cover_window_core
  import mcw_pkg::*;
#(
  parameter int unsigned MAX_WORDS    = 1024,
  parameter int unsigned WINDOW_DEPTH = 4096,
  parameter int unsigned POS_BITS     = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [NWORDS_W-1:0]  cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // position, word_id
  input  wire logic                 s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,  // min_length
  output logic [M_TUSER_W-1:0]      m_axis_tuser   // covered, overflow
);

  mcw_cmd_t    cmd;
  mcw_status_t st;
  logic        cov;
  logic        ovf;

  assign cfg_ready_o = 1'b1;

  mcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  mcw_datapath #(
    .MAX_WORDS    (MAX_WORDS),
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .POS_BITS     (POS_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .position_i    (s_axis_tdata[POS_IN_W-1:0]),
    .word_id_i     (s_axis_tdata[POS_IN_W +: WORD_IN_W]),
    .last_in_set_i (s_axis_tlast),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .min_length_o  (m_axis_tdata),
    .covered_o     (cov),
    .overflow_o    (ovf)
  );

  assign m_axis_tuser = {ovf, cov};

endmodule

`default_nettype wire

// File: tb/tb_min_cover_window_core.sv
// self-checking testbench for min_cover_window_core with its own window predictor
`timescale 1ns / 1ps

module tb_min_cover_window_core;
  import mcw_pkg::*;

  localparam int unsigned MAX_W      = 1024;
  localparam int unsigned WIN_D      = 4096;
  localparam int unsigned STALL_MAX  = 100000;
  localparam int unsigned SETTLE_CYC = 40;
  localparam int unsigned SHUF_WORDS = 128;
  localparam int unsigned LONG_RUN   = 200;
  localparam int unsigned RAND_HALF  = 64;
  localparam logic [NWORDS_W-1:0] WORDS_ZERO = '0;
  localparam logic [NWORDS_W-1:0] WORDS_TWO  = NWORDS_W'(2);
  localparam logic [NWORDS_W-1:0] WORDS_SHUF = NWORDS_W'(SHUF_WORDS);
  localparam logic [NWORDS_W-1:0] WORDS_TOP  = '1;

  typedef struct packed {
    logic [LEN_W-1:0] min_len;
    logic             covered;
    logic             ovf;
  } span_result_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [NWORDS_W-1:0]   cfg_val;
    logic [POS_IN_W-1:0]   pos;
    logic [WORD_IN_W-1:0]  wid;
    logic                  last;
    logic                  typed;
    span_result_t          want;
  } stim_row_t;

  localparam span_result_t NOT_COVERED = '{ALL_ONES32, 1'b0, 1'b0};
  localparam span_result_t UNIT_SPAN   = '{32'd1, 1'b1, 1'b0};
  localparam span_result_t NO_TYPED    = '0;

  localparam int unsigned DIR_ROWS = 23;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{1'b0, WORDS_ZERO, 32'h0000_0000, 10'd0,    1'b1, 1'b1, UNIT_SPAN},
    '{1'b0, WORDS_ZERO, 32'hFFFF_FFFF, 10'd1,    1'b1, 1'b1, NOT_COVERED},
    '{1'b0, WORDS_ZERO, 32'h0000_0005, 10'd0,    1'b0, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'hFFFF_FFFF, 10'd0,    1'b1, 1'b1, UNIT_SPAN},
    '{1'b1, WORDS_ZERO, 32'h0000_0000, 10'd0,    1'b0, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'h0000_0007, 10'd1,    1'b1, 1'b1, NOT_COVERED},
    '{1'b0, WORDS_ZERO, 32'h0000_0008, 10'd0,    1'b1, 1'b1, UNIT_SPAN},
    '{1'b1, WORDS_TWO,  32'h0000_0000, 10'd0,    1'b0, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'h0000_000A, 10'd0,    1'b0, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'h0000_0005, 10'd1,    1'b1, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'h0000_0001, 10'd0,    1'b0, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'h0000_0000, 10'd1,    1'b1, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'h0000_0000, 10'd0,    1'b0, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'h0000_0003, 10'd0,    1'b0, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'h0000_0004, 10'd1,    1'b0, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'h0000_0006, 10'd0,    1'b0, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'h0000_0064, 10'd1,    1'b1, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'hFFFF_FFFE, 10'd1,    1'b0, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'hFFFF_FFFF, 10'd0,    1'b1, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'h0000_0003, 10'd2,    1'b1, 1'b1, NOT_COVERED},
    '{1'b1, WORDS_TOP,  32'h0000_0000, 10'd0,    1'b0, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'hFFFF_FFFF, 10'd1023, 1'b0, 1'b0, NO_TYPED},
    '{1'b0, WORDS_ZERO, 32'h0000_0000, 10'd0,    1'b1, 1'b1, NOT_COVERED}
  };

  localparam int SRC_PCT  [4] = '{0, 48, 0, 26};
  localparam int SINK_PCT [4] = '{0, 0, 48, 26};
  localparam int PHASE_WORDS [4] = '{4, 2, 7, 3};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [NWORDS_W-1:0]   cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;  // position, word_id
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;       // min_length
  logic [M_TUSER_W-1:0]  m_axis_tuser;       // covered, overflow

  min_cover_window_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [NWORDS_W-1:0]  words_cfg;
  logic [POS_IN_W-1:0]  last_pos_mem [MAX_W];
  logic                 seen_mem [MAX_W];
  int unsigned          distinct_q;
  logic [POS_IN_W-1:0]  win_pos_mem [WIN_D];
  logic [WORD_IN_W-1:0] win_id_mem [WIN_D];
  int unsigned          head_q;
  int unsigned          tail_q;
  int unsigned          fill_q;
  logic [LEN_W-1:0]     best_q;
  logic                 ovf_q;
  logic                 cov_q;

  span_result_t pending_spans [$];
  int mismatch_count = 0;
  int result_count = 0;
  int covered_count = 0;
  int overflow_count = 0;
  int item_count = 0;
  int cfg_writes = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int unsigned stall_cycles = 0;

  function automatic int unsigned eff_words();
    int unsigned n;
    n = 32'(words_cfg);
    if (n == 0) n = 1;
    if (n > MAX_W) n = MAX_W;
    return n;
  endfunction

  task automatic clear_cover_set();
    for (int i = 0; i < MAX_W; i++) seen_mem[i] = 1'b0;
    distinct_q = 0;
    head_q = 0;
    tail_q = 0;
    fill_q = 0;
    best_q = ALL_ONES32;
    ovf_q = 1'b0;
    cov_q = 1'b0;
  endtask

  task automatic track_occurrence(input logic [POS_IN_W-1:0] pos,
                                  input logic [WORD_IN_W-1:0] wid, input logic last,
                                  output bit has_res, output span_result_t res);
    int unsigned n;
    logic [POS_IN_W-1:0] diff;
    logic [POS_IN_W:0] span;
    logic [LEN_W-1:0] s;
    n = eff_words();
    has_res = 1'b0;
    res = '0;
    if (wid < n) begin
      if (!seen_mem[wid]) begin
        seen_mem[wid] = 1'b1;
        distinct_q++;
      end
      last_pos_mem[wid] = pos;
      // full window: oldest entry is lost
      if (fill_q >= WIN_D) begin
        head_q = (head_q + 1) % WIN_D;
        fill_q--;
        ovf_q = 1'b1;
      end
      win_pos_mem[tail_q] = pos;
      win_id_mem[tail_q] = wid;
      tail_q = (tail_q + 1) % WIN_D;
      fill_q++;
      while (fill_q > 0 && last_pos_mem[win_id_mem[head_q]] != win_pos_mem[head_q]) begin
        head_q = (head_q + 1) % WIN_D;
        fill_q--;
      end
      if (distinct_q >= n && fill_q > 0) begin
        diff = pos - win_pos_mem[head_q];
        span = {1'b0, diff} + 33'd1;
        s = span[POS_IN_W] ? ALL_ONES32 : span[POS_IN_W-1:0];
        if (s < best_q) best_q = s;
        cov_q = 1'b1;
      end
    end
    if (last) begin
      has_res = 1'b1;
      res = '{best_q, cov_q, ovf_q};
      clear_cover_set();
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_occ(input logic [POS_IN_W-1:0] pos, input logic [WORD_IN_W-1:0] wid,
                          input logic last, input logic typed, input span_result_t typed_res);
    bit has_res;
    span_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-POS_IN_W-WORD_IN_W){1'b0}}, wid, pos};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_occurrence(pos, wid, last, has_res, res);
    item_count++;
    if (has_res) pending_spans.insert(pending_spans.size(), typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  // only while the block is idle
  task automatic write_words(input logic [NWORDS_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_spans.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    words_cfg = val;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one set of random occurrences, mostly sorted and in range
  task automatic send_random_set(output int sent);
    int unsigned n;
    int unsigned len;
    int unsigned r;
    logic [POS_IN_W-1:0] cur;
    logic [WORD_IN_W-1:0] wid;
    n = eff_words();
    len = $urandom_range(1, 3 * n + 4);
    case ($urandom_range(3))
      0: cur = $urandom_range(0, 15);
      1: cur = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: cur = $urandom;
    endcase
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 88) wid = WORD_IN_W'($urandom_range(0, n - 1));
      else wid = WORD_IN_W'($urandom);
      send_occ(cur, wid, i == len - 1, 1'b0, NO_TYPED);
      r = $urandom_range(99);
      if (r < 88) cur = cur + $urandom_range(1, 4);
      else if (r < 94) cur = cur + $urandom_range(1, 1000000);
      else if (r < 97) cur = cur + $urandom;
      else cur = cur - $urandom_range(0, 3);
    end
    sent = len;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    span_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_spans.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: len %h covered %b overflow %b",
                   m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
      end else begin
        want = pending_spans.pop_front();
        result_count++;
        if (want.covered) covered_count++;
        if (want.ovf) overflow_count++;
        if (m_axis_tdata !== want.min_len || m_axis_tuser[0] !== want.covered ||
            m_axis_tuser[1] !== want.ovf) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at result %0d: want len %h cov %b ovf %b, got len %h cov %b ovf %b",
                     result_count, want.min_len, want.covered, want.ovf,
                     m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles = 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("watchdog: no transaction for %0d cycles", stall_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int perm [SHUF_WORDS];
    int j;
    int tmp;
    words_cfg = NWORDS_W'(1);
    clear_cover_set();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].is_cfg) write_words(DIRECTED[i].cfg_val);
      else send_occ(DIRECTED[i].pos, DIRECTED[i].wid, DIRECTED[i].last,
                    DIRECTED[i].typed, DIRECTED[i].want);
    end

    // every id once in shuffled order, with some repeats
    src_idle_pct = SRC_PCT[3];
    sink_stall_pct = SINK_PCT[3];
    write_words(WORDS_SHUF);
    for (int i = 0; i < SHUF_WORDS; i++) perm[i] = i;
    for (int i = SHUF_WORDS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < SHUF_WORDS; i++) begin
      send_occ(32'd3 * i, WORD_IN_W'(perm[i]), i == SHUF_WORDS - 1, 1'b0, NO_TYPED);
      if (i < SHUF_WORDS - 1 && $urandom_range(9) == 0)
        send_occ(32'd3 * i + 1, WORD_IN_W'(perm[$urandom_range(0, i)]), 1'b0, 1'b0,
                 NO_TYPED);
    end

    // long set whose first id comes back halfway, dropping a long run of heads
    src_idle_pct = 0;
    sink_stall_pct = 0;
    write_words(WORDS_TWO);
    send_occ(32'd0, 10'd0, 1'b0, 1'b0, NO_TYPED);
    for (int i = 1; i <= LONG_RUN; i++)
      send_occ(i, (i == LONG_RUN / 2) ? 10'd0 : 10'd1, i == LONG_RUN, 1'b0, NO_TYPED);

    for (int m = 0; m < 4; m++) begin
      src_idle_pct = SRC_PCT[m];
      sink_stall_pct = SINK_PCT[m];
      for (int h = 0; h < 2; h++) begin
        write_words(h == 0 ? NWORDS_W'(PHASE_WORDS[m]) : NWORDS_W'($urandom_range(1, 10)));
        sent = 0;
        while (sent < RAND_HALF) begin
          send_random_set(j);
          sent += j;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    mismatch_count += pending_spans.size();

    $display("sent %0d occurrences over %0d word-count settings, checked %0d set results",
             item_count, cfg_writes, result_count);
    $display("covered sets %0d, window overflow sets %0d, mismatches %0d",
             covered_count, overflow_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
